>>> rtl/core/multi_queue_shared_ring_buffer_core_defines.svh
// Assertion macros shared by the multi-queue shared ring buffer RTL.
// Standalone header: no dependencies; assertions compile away under SYNTHESIS.
`ifndef MULTI_QUEUE_SHARED_RING_BUFFER_CORE_DEFINES_SVH
`define MULTI_QUEUE_SHARED_RING_BUFFER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds
`define MQSRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mqsrb assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante
`define MQSRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mqsrb assertion failed");
`else
`define MQSRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MQSRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/mqsrb_pkg.sv
// Shared types and constants for the multi-queue shared ring buffer.
// No dependencies; imported by every other RTL file of the block but mqsrb_ram and the macro header.
package mqsrb_pkg;

    // Default sizing
    localparam int STORE_DEPTH_DEF = 64;
    localparam int QUEUE_COUNT_DEF = 4;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int QID_W     = 2;
    localparam int TAG_W     = 16;
    localparam int PAY_W     = 32;
    localparam int ENTRY_W   = TAG_W + PAY_W;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 7;
    localparam int BASE_W    = 6;
    localparam int BASE_VALS = 2 ** BASE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam logic CFG_SEL_BASE = 1'b0;
    localparam logic CFG_SEL_SIZE = 1'b1;

    // Register reset values
    localparam int BASE_RST_STEP = 16;
    localparam int SIZE_RST      = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_QRST = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Result control handed from the queue controller to the output stage
    typedef struct packed {
        t_status            status;
        logic               hit;
        logic [CNT_W-1:0]   count;
    } t_res_info;

endpackage

>>> rtl/core/mqsrb_chan_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mqsrb_pkg for the field widths.
interface mqsrb_cmd_if import mqsrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [QID_W-1:0]   queue_sel;
    logic [TAG_W-1:0]   event_tag;
    logic [PAY_W-1:0]   event_payload;

    modport source (output valid, cmd, queue_sel, event_tag, event_payload, input ready);
    modport sink   (input valid, cmd, queue_sel, event_tag, event_payload, output ready);
endinterface

interface mqsrb_res_if import mqsrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [TAG_W-1:0]   out_tag;
    logic [PAY_W-1:0]   out_payload;
    logic [CNT_W-1:0]   queue_count;

    modport source (output valid, status, out_tag, out_payload, queue_count, input ready);
    modport sink   (input valid, status, out_tag, out_payload, queue_count, output ready);
endinterface

>>> rtl/core/mqsrb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module mqsrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, read data updates only on read enable
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mqsrb_cfg.sv
// Segment configuration registers: per-queue base (reduced into the store) and size.
// Depends on mqsrb_pkg for widths and reset values.
module mqsrb_cfg import mqsrb_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [CFG_IDX_W-1:0]   i_index,
    input  logic [CFG_DATA_W-1:0]  i_wdata,
    output logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] o_base [QUEUE_COUNT],
    output logic [CNT_W-1:0]       o_size [QUEUE_COUNT]
);

    localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int DW   = $clog2(STORE_DEPTH + 1);
    localparam int SZ_W = (CNT_W > DW) ? CNT_W : DW;

    logic [AW-1:0]              base_tab [BASE_VALS];
    logic [AW-1:0]              r_base [QUEUE_COUNT];
    logic [CNT_W-1:0]           r_size [QUEUE_COUNT];
    logic [CFG_IDX_W-2:0]       sel_q;
    logic                       sel_ok;

    // Base value reduced modulo the store depth, one constant per base code
    for (genvar g = 0; g < BASE_VALS; g++) begin : g_base_tab
        localparam logic [AW-1:0] BASE_MOD = AW'(g % STORE_DEPTH);
        assign base_tab[g] = BASE_MOD;
    end

    // Clamp a size to the store depth
    function automatic logic [CNT_W-1:0] cap_size(input logic [CNT_W-1:0] v);
        logic [SZ_W-1:0] lim;
        lim = SZ_W'(STORE_DEPTH);
        if (SZ_W'(v) > lim) begin
            return CNT_W'(STORE_DEPTH);
        end
        return v;
    endfunction

    // Register index: upper bits pick the queue, low bit picks base or size
    assign sel_q  = i_index[CFG_IDX_W-1:1];
    assign sel_ok = ({1'b0, sel_q} < 3'(QUEUE_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                r_base[q] <= base_tab[BASE_W'(q * BASE_RST_STEP)];
                r_size[q] <= cap_size(CNT_W'(SIZE_RST));
            end
        end else if (i_we && sel_ok) begin
            if (i_index[0] == CFG_SEL_SIZE) begin
                r_size[sel_q[QW-1:0]] <= cap_size(i_wdata[CNT_W-1:0]);
            end else begin
                r_base[sel_q[QW-1:0]] <= base_tab[i_wdata[BASE_W-1:0]];
            end
        end
    end

    assign o_base = r_base;
    assign o_size = r_size;

endmodule

>>> rtl/core/mqsrb_qctl.sv
// Queue controller: per-queue offsets and counts, full/empty decisions, store addressing.
// Depends on mqsrb_pkg and the assertion macro header.
`include "multi_queue_shared_ring_buffer_core_defines.svh"
module mqsrb_qctl import mqsrb_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  t_cmd                   i_cmd,
    input  logic [QID_W-1:0]       i_qid,
    input  logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] i_base [QUEUE_COUNT],
    input  logic [CNT_W-1:0]       i_size [QUEUE_COUNT],
    output logic                   o_ram_we,
    output logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] o_ram_waddr,
    output logic                   o_ram_re,
    output logic [((STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1)-1:0] o_ram_raddr,
    output t_res_info              o_info
);

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CMP_W = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    logic [AW-1:0]      r_rd  [QUEUE_COUNT];
    logic [AW-1:0]      r_wr  [QUEUE_COUNT];
    logic [CNT_W-1:0]   r_cnt [QUEUE_COUNT];

    logic [AW-1:0]      n_rd;
    logic [AW-1:0]      n_wr;
    logic [CNT_W-1:0]   n_cnt;

    logic               q_ok;
    logic [QW-1:0]      q;
    logic [AW-1:0]      base;
    logic [CNT_W-1:0]   size;
    logic [AW-1:0]      rd;
    logic [AW-1:0]      wr;
    logic [CNT_W-1:0]   cnt;
    logic               full;
    logic               empty;
    logic [AW:0]        rd_inc;
    logic [AW:0]        wr_inc;
    logic [AW-1:0]      rd_adv;
    logic [AW-1:0]      wr_adv;
    logic [AW:0]        rd_sum;
    logic [AW:0]        wr_sum;
    logic [AW:0]        rd_wrap;
    logic [AW:0]        wr_wrap;

    // Select the addressed queue
    assign q_ok  = ({1'b0, i_qid} < 3'(QUEUE_COUNT));
    assign q     = i_qid[QW-1:0];
    assign base  = i_base[q];
    assign size  = i_size[q];
    assign rd    = r_rd[q];
    assign wr    = r_wr[q];
    assign cnt   = r_cnt[q];
    assign full  = (cnt >= size);
    assign empty = (cnt == '0) || (size == '0);

    // Advance offsets, wrap to zero at or past the segment size
    assign rd_inc = {1'b0, rd} + 1'b1;
    assign wr_inc = {1'b0, wr} + 1'b1;
    assign rd_adv = (CMP_W'(rd_inc) >= CMP_W'(size)) ? '0 : rd_inc[AW-1:0];
    assign wr_adv = (CMP_W'(wr_inc) >= CMP_W'(size)) ? '0 : wr_inc[AW-1:0];

    // Store address: base plus offset, folded once into the store
    assign rd_sum  = {1'b0, base} + {1'b0, rd};
    assign wr_sum  = {1'b0, base} + {1'b0, wr};
    assign rd_wrap = rd_sum - (AW + 1)'(STORE_DEPTH);
    assign wr_wrap = wr_sum - (AW + 1)'(STORE_DEPTH);
    assign o_ram_raddr = (rd_sum >= (AW + 1)'(STORE_DEPTH)) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];
    assign o_ram_waddr = (wr_sum >= (AW + 1)'(STORE_DEPTH)) ? wr_wrap[AW-1:0] : wr_sum[AW-1:0];

    // Decide the command outcome and next queue state
    always_comb begin
        n_rd     = rd;
        n_wr     = wr;
        n_cnt    = cnt;
        o_ram_we = 1'b0;
        o_ram_re = 1'b0;
        o_info.status = ST_OK;
        o_info.hit    = 1'b0;
        o_info.count  = '0;
        if (!q_ok) begin
            case (i_cmd)
                CMD_ENQ:  o_info.status = ST_FULL;
                CMD_DEQ:  o_info.status = ST_EMPTY;
                CMD_PEEK: o_info.status = ST_EMPTY;
                default:  o_info.status = ST_OK;
            endcase
        end else begin
            case (i_cmd)
                CMD_ENQ: begin
                    if (full) begin
                        o_info.status = ST_FULL;
                    end else begin
                        o_ram_we = i_fire;
                        n_wr     = wr_adv;
                        n_cnt    = cnt + 1'b1;
                    end
                end
                CMD_DEQ: begin
                    if (empty) begin
                        o_info.status = ST_EMPTY;
                    end else begin
                        o_ram_re   = i_fire;
                        o_info.hit = 1'b1;
                        n_rd       = rd_adv;
                        n_cnt      = cnt - 1'b1;
                    end
                end
                CMD_PEEK: begin
                    if (empty) begin
                        o_info.status = ST_EMPTY;
                    end else begin
                        o_ram_re   = i_fire;
                        o_info.hit = 1'b1;
                    end
                end
                default: begin
                    n_rd  = '0;
                    n_wr  = '0;
                    n_cnt = '0;
                end
            endcase
            o_info.count = n_cnt;
        end
    end

    // Hold per-queue offsets and counts; update the addressed queue on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUEUE_COUNT; k++) begin
                r_rd[k]  <= '0;
                r_wr[k]  <= '0;
                r_cnt[k] <= '0;
            end
        end else if (i_fire && q_ok) begin
            r_rd[q]  <= n_rd;
            r_wr[q]  <= n_wr;
            r_cnt[q] <= n_cnt;
        end
    end

    // An accepted enqueue grows its queue by exactly one entry
    `MQSRB_ASSERT_NEXT(a_enq_grows, i_clk, i_rst_n, i_fire && q_ok && (i_cmd == CMD_ENQ) && !full, r_cnt[$past(q)] == $past(cnt) + 1'b1)
    // A queue reset leaves count and read offset at zero
    `MQSRB_ASSERT_NEXT(a_qrst_clears, i_clk, i_rst_n, i_fire && q_ok && (i_cmd == CMD_QRST), (r_cnt[$past(q)] == '0) && (r_rd[$past(q)] == '0))
    // Store is never both written and read by one command
    `MQSRB_ASSERT_SAME(a_one_port, i_clk, i_rst_n, o_ram_we, !o_ram_re)

endmodule

>>> rtl/core/multi_queue_shared_ring_buffer_core.sv
// A result is valid in the cycle after its command transfer.
// Throughput: one command per cycle while the result channel is ready; the store read
// is registered once and held in the result stage while the result channel stalls.
// Reset (synchronous, active low) clears all offsets, counts and the result stage and
// restores default segment bases and sizes; the entry store is not cleared.
// Depends on mqsrb_pkg, the channel interfaces, mqsrb_cfg, mqsrb_qctl and mqsrb_ram.
`include "multi_queue_shared_ring_buffer_core_defines.svh"
module multi_queue_shared_ring_buffer_core import mqsrb_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mqsrb_cmd_if.sink              i_cmd,
    mqsrb_res_if.source            o_res,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [AW-1:0]      seg_base [QUEUE_COUNT];
    logic [CNT_W-1:0]   seg_size [QUEUE_COUNT];
    logic               fire;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_res_info          info;
    t_res_info          r_info;
    logic               r_out_valid;

    // Accept whenever the result stage is free or drains this cycle
    assign i_cmd.ready = i_rst_n && (!r_out_valid || o_res.ready);
    assign fire        = i_cmd.valid && i_cmd.ready;

    mqsrb_cfg #(
        .STORE_DEPTH (STORE_DEPTH),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_base  (seg_base),
        .o_size  (seg_size)
    );

    mqsrb_qctl #(
        .STORE_DEPTH (STORE_DEPTH),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_qctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_cmd       (t_cmd'(i_cmd.cmd)),
        .i_qid       (i_cmd.queue_sel),
        .i_base      (seg_base),
        .i_size      (seg_size),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_info      (info)
    );

    mqsrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_cmd.event_tag, i_cmd.event_payload}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result stage: load on transfer in, drop on transfer out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_info <= info;
        end
    end

    // Drive the result; entry fields come from the held store read
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_info.status;
    assign o_res.queue_count = r_info.count;
    assign o_res.out_tag     = r_info.hit ? ram_rdata[ENTRY_W-1:PAY_W] : '0;
    assign o_res.out_payload = r_info.hit ? ram_rdata[PAY_W-1:0] : '0;

    // Every accepted command produces a pending result next cycle
    `MQSRB_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, fire, r_out_valid)
    // A stalled result blocks further commands
    `MQSRB_ASSERT_SAME(a_stall_blocks, i_clk, i_rst_n, r_out_valid && !o_res.ready, !i_cmd.ready)
    // A successful read result always reports ok status
    `MQSRB_ASSERT_SAME(a_hit_is_ok, i_clk, i_rst_n, r_out_valid && r_info.hit, r_info.status == ST_OK)

endmodule

>>> tb/sv/mqsrb_result_checker.sv
// Scoreboard for the multi-queue shared ring buffer: predicts each result from the
// command and register write transfers it sees and compares every result transfer.
// Depends on mqsrb_pkg and the channel interfaces in mqsrb_chan_if.sv.
module mqsrb_result_checker import mqsrb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    mqsrb_cmd_if                   cmd_mon,
    mqsrb_res_if                   res_mon,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   tag;
        logic [PAY_W-1:0]   payload;
        logic [CNT_W-1:0]   count;
    } t_result;

    // Shadow of the block: shared store, per-queue segment and FIFO pointers
    logic [ENTRY_W-1:0] entry_mem [STORE_DEPTH_DEF];
    logic [BASE_W-1:0]  seg_base  [QUEUE_COUNT_DEF];
    logic [CNT_W-1:0]   seg_size  [QUEUE_COUNT_DEF];
    logic [BASE_W-1:0]  rd_off    [QUEUE_COUNT_DEF];
    logic [BASE_W-1:0]  wr_off    [QUEUE_COUNT_DEF];
    logic [CNT_W-1:0]   fill      [QUEUE_COUNT_DEF];

    t_result pending_results[$];
    int      fail_count;
    int      checked;

    initial begin
        fail_count = 0;
        checked    = 0;
    end

    // Advance an offset, wrapping to the segment start at or past the size
    function automatic logic [BASE_W-1:0] step_offset(logic [BASE_W-1:0] off,
                                                      logic [CNT_W-1:0] span);
        logic [CNT_W-1:0] nxt;
        nxt = {1'b0, off} + 1'b1;
        return (nxt >= span) ? '0 : nxt[BASE_W-1:0];
    endfunction

    // Apply one command to the shadow state and return the result it produces
    function automatic t_result apply_command(t_cmd op, logic [QID_W-1:0] q,
                                              logic [TAG_W-1:0] tag,
                                              logic [PAY_W-1:0] payload);
        t_result            r;
        logic [CNT_W-1:0]   span;
        logic [BASE_W-1:0]  slot;
        logic [ENTRY_W-1:0] word;
        r.status  = ST_OK;
        r.tag     = '0;
        r.payload = '0;
        span = (seg_size[q] > CNT_W'(STORE_DEPTH_DEF)) ? CNT_W'(STORE_DEPTH_DEF)
                                                       : seg_size[q];
        case (op)
            CMD_ENQ: begin
                if (fill[q] >= span) begin
                    r.status = ST_FULL;
                end else begin
                    // 6-bit sum wraps the segment around the end of the store
                    slot = seg_base[q] + wr_off[q];
                    entry_mem[slot] = {tag, payload};
                    wr_off[q] = step_offset(wr_off[q], span);
                    fill[q]   = fill[q] + 1'b1;
                end
            end
            CMD_DEQ, CMD_PEEK: begin
                if (fill[q] == '0 || span == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = seg_base[q] + rd_off[q];
                    word = entry_mem[slot];
                    r.tag     = word[ENTRY_W-1:PAY_W];
                    r.payload = word[PAY_W-1:0];
                    if (op == CMD_DEQ) begin
                        rd_off[q] = step_offset(rd_off[q], span);
                        fill[q]   = fill[q] - 1'b1;
                    end
                end
            end
            default: begin
                rd_off[q] = '0;
                wr_off[q] = '0;
                fill[q]   = '0;
            end
        endcase
        r.count = fill[q];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result            want;
        logic [QID_W-1:0]   cq;
        if (!i_rst_n) begin
            // Restore default segments and empty every queue; store keeps contents
            for (int q = 0; q < QUEUE_COUNT_DEF; q++) begin
                seg_base[q] = BASE_W'(q * BASE_RST_STEP);
                seg_size[q] = CNT_W'(SIZE_RST);
                rd_off[q]   = '0;
                wr_off[q]   = '0;
                fill[q]     = '0;
            end
            pending_results.delete();
        end else begin
            // Result first: it always belongs to an earlier command transfer
            if (res_mon.valid && res_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    checked++;
                    if (res_mon.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, res_mon.status);
                        fail_count++;
                    end
                    if (res_mon.out_tag !== want.tag) begin
                        $error("out_tag mismatch: expected %h, actual %h",
                               want.tag, res_mon.out_tag);
                        fail_count++;
                    end
                    if (res_mon.out_payload !== want.payload) begin
                        $error("out_payload mismatch: expected %h, actual %h",
                               want.payload, res_mon.out_payload);
                        fail_count++;
                    end
                    if (res_mon.queue_count !== want.count) begin
                        $error("queue_count mismatch: expected %0d, actual %0d",
                               want.count, res_mon.queue_count);
                        fail_count++;
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready) begin
                pending_results.push_back(apply_command(t_cmd'(cmd_mon.cmd),
                    cmd_mon.queue_sel, cmd_mon.event_tag, cmd_mon.event_payload));
            end
            // Register write: upper index bits pick the queue, bit 0 base or size
            if (i_cfg_we) begin
                cq = i_cfg_index[CFG_IDX_W-1:1];
                if (i_cfg_index[0] == CFG_SEL_BASE)
                    seg_base[cq] = i_cfg_wdata[BASE_W-1:0];
                else
                    seg_size[cq] = i_cfg_wdata[CNT_W-1:0];
            end
        end
        o_pending <= pending_results.size();
        o_errors  <= fail_count;
        o_checked <= checked;
    end

endmodule

>>> tb/sv/tb_multi_queue_shared_ring_buffer_core.sv
// Top of the multi-queue shared ring buffer testbench: clock, reset, command and
// register stimulus, result back-pressure and the verdict.
// Depends on mqsrb_pkg, mqsrb_chan_if.sv, the block RTL and mqsrb_result_checker.
module tb_multi_queue_shared_ring_buffer_core import mqsrb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LAYOUT_ROUNDS    = 8;
    localparam int          ITEMS_PER_LAYOUT = 115;
    localparam int          HOLD_CYCLES      = 80;
    localparam logic [7:0]  STALL_PATTERN    = 8'b1011_0110;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int                     err_total;
    int                     pend_total;
    int                     checked_total;
    int unsigned            issued;
    int unsigned            layouts;
    int unsigned            burst_left;
    int unsigned            long_holds;
    bit                     steady;

    logic [BASE_W-1:0]      plan_base [QUEUE_COUNT_DEF];
    logic [CNT_W-1:0]       plan_size [QUEUE_COUNT_DEF];

    mqsrb_cmd_if cmd_ch ();
    mqsrb_res_if res_ch ();

    multi_queue_shared_ring_buffer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    mqsrb_result_checker result_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .cmd_mon     (cmd_ch),
        .res_mon     (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (err_total),
        .o_pending   (pend_total),
        .o_checked   (checked_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one command, opening a random gap whenever a burst runs out, except in steady mode
    task automatic issue_command(t_cmd op, logic [QID_W-1:0] q,
                                 logic [TAG_W-1:0] tag, logic [PAY_W-1:0] payload);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = steady ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        cmd_ch.valid         <= 1'b1;
        cmd_ch.cmd           <= op;
        cmd_ch.queue_sel     <= q;
        cmd_ch.event_tag     <= tag;
        cmd_ch.event_payload <= payload;
        do @(posedge i_clk); while (!cmd_ch.ready);
        issued++;
    endtask

    // Random command; enq_pct steers the queues toward full or toward empty
    task automatic random_command(int unsigned enq_pct);
        int unsigned      roll;
        t_cmd             op;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
        roll = $urandom_range(0, 99);
        if (roll < enq_pct)
            op = CMD_ENQ;
        else if (roll < 80)
            op = CMD_DEQ;
        else if (roll < 95)
            op = CMD_PEEK;
        else
            op = CMD_QRST;
        tag     = TAG_W'($urandom());
        payload = $urandom();
        if ($urandom_range(0, 15) == 0)
            tag = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 15) == 0)
            payload = $urandom_range(0, 1) ? '1 : '0;
        issue_command(op, QID_W'($urandom_range(0, QUEUE_COUNT_DEF - 1)), tag, payload);
    endtask

    // Hold input until every result is back, plus the output stage latency
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pend_total != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // Write the planned base and size of every queue, block idle
    task automatic apply_layout();
        for (int q = 0; q < QUEUE_COUNT_DEF; q++) begin
            write_register({QID_W'(q), CFG_SEL_BASE}, CFG_DATA_W'(plan_base[q]));
            write_register({QID_W'(q), CFG_SEL_SIZE}, plan_size[q]);
        end
        cfg_we <= 1'b0;
        layouts++;
    endtask

    // Mostly small segments, with size zero, one, full store and oversize mixed in
    task automatic plan_random_layout();
        for (int q = 0; q < QUEUE_COUNT_DEF; q++) begin
            plan_base[q] = BASE_W'($urandom_range(0, BASE_VALS - 1));
            case ($urandom_range(0, 7))
                0:       plan_size[q] = '0;
                1:       plan_size[q] = 7'd1;
                2:       plan_size[q] = CNT_W'(STORE_DEPTH_DEF);
                3:       plan_size[q] = CNT_W'($urandom_range(STORE_DEPTH_DEF + 1, 127));
                4:       plan_size[q] = CNT_W'($urandom_range(9, STORE_DEPTH_DEF));
                default: plan_size[q] = CNT_W'($urandom_range(2, 8));
            endcase
        end
    endtask

    // Result side: rotating stall modes, plus long holdoffs to back up the input
    initial begin : result_sink
        int unsigned tick;
        int unsigned hold_left;
        int unsigned taken;
        int unsigned next_hold;
        tick       = 0;
        hold_left  = 0;
        taken      = 0;
        next_hold  = 150;
        long_holds = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                taken++;
            tick++;
            if (hold_left == 0 && taken >= next_hold) begin
                hold_left = HOLD_CYCLES;
                next_hold += 400;
                long_holds++;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case ((tick / 64) % 4)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= $urandom_range(0, 1);
                    2:       res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: res_ch.ready <= STALL_PATTERN[tick % 8];
                endcase
            end
        end
    end

    initial begin : stimulus
        int unsigned enq_pct;
        issued     = 0;
        layouts    = 0;
        burst_left = 0;
        steady     = 1'b0;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_wdata            <= '0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.cmd           <= CMD_ENQ;
        cmd_ch.queue_sel     <= '0;
        cmd_ch.event_tag     <= '0;
        cmd_ch.event_payload <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every queue past full under the reset layout so the whole store is
        // written before anything can be read
        for (int q = 0; q < QUEUE_COUNT_DEF; q++) begin
            for (int k = 0; k <= SIZE_RST; k++) begin
                if (k == 0)
                    issue_command(CMD_ENQ, QID_W'(q), '1, '1);
                else if (k == 1)
                    issue_command(CMD_ENQ, QID_W'(q), '0, '0);
                else
                    issue_command(CMD_ENQ, QID_W'(q), TAG_W'($urandom()), $urandom());
            end
        end

        // Peek, dequeue, and reset of a queue, then empty reads
        issue_command(CMD_PEEK, 2'd0, '0, '0);
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_PEEK, 2'd3, '0, '0);
        issue_command(CMD_QRST, 2'd1, '0, '0);
        issue_command(CMD_DEQ,  2'd1, '0, '0);
        issue_command(CMD_PEEK, 2'd1, '0, '0);
        issue_command(CMD_ENQ,  2'd1, 16'h5A5A, 32'hA5A5_5A5A);
        issue_command(CMD_DEQ,  2'd1, '0, '0);
        issue_command(CMD_QRST, 2'd2, '0, '0);
        settle();

        // Extreme layout: segment wrapping past the store end, size zero,
        // oversize, whole store; queue 0 shrinks while still holding entries
        plan_base[0] = BASE_W'(BASE_VALS - 1);     plan_size[0] = 7'd2;
        plan_base[1] = '0;                          plan_size[1] = '0;
        plan_base[2] = 6'd10;                       plan_size[2] = '1;
        plan_base[3] = 6'd48;                       plan_size[3] = CNT_W'(STORE_DEPTH_DEF);
        apply_layout();
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_ENQ,  2'd0, 16'h1234, 32'h0000_0001);
        issue_command(CMD_ENQ,  2'd1, 16'h4321, 32'h8000_0000);
        issue_command(CMD_DEQ,  2'd1, '0, '0);
        issue_command(CMD_QRST, 2'd0, '0, '0);
        issue_command(CMD_ENQ,  2'd0, '1, 32'h0F0F_0F0F);
        issue_command(CMD_ENQ,  2'd0, '0, 32'hF0F0_F0F0);
        issue_command(CMD_ENQ,  2'd0, 16'h00FF, '1);
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_DEQ,  2'd0, '0, '0);
        issue_command(CMD_ENQ,  2'd3, 16'hFF00, '0);
        issue_command(CMD_PEEK, 2'd2, '0, '0);
        issue_command(CMD_ENQ,  2'd2, 16'hBEEF, 32'hCAFE_F00D);

        // Random traffic over a series of layouts, last one back to reset values
        for (int round = 1; round < LAYOUT_ROUNDS; round++) begin
            if (round > 1) begin
                settle();
                if (round == LAYOUT_ROUNDS - 1) begin
                    for (int q = 0; q < QUEUE_COUNT_DEF; q++) begin
                        plan_base[q] = BASE_W'(q * BASE_RST_STEP);
                        plan_size[q] = CNT_W'(SIZE_RST);
                    end
                end else begin
                    plan_random_layout();
                end
                apply_layout();
            end
            enq_pct = $urandom_range(30, 60);
            steady  = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_LAYOUT; n++)
                random_command(enq_pct);
        end

        settle();
        repeat (4) @(posedge i_clk);
        $display("Run covered %0d commands across %0d segment layouts, %0d results checked,",
                 issued, layouts, checked_total);
        $display("with %0d long output holdoffs backing up the command channel.", long_holds);
        if (err_total == 0 && pend_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake
    initial begin : watchdog
        #2_000_000;
        $display("Timeout: simulation did not finish in the allotted time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> multi_queue_shared_ring_buffer_core.f
+incdir+rtl/core
rtl/core/mqsrb_pkg.sv
rtl/core/mqsrb_chan_if.sv
rtl/core/mqsrb_ram.sv
rtl/core/mqsrb_cfg.sv
rtl/core/mqsrb_qctl.sv
rtl/core/multi_queue_shared_ring_buffer_core.sv
tb/sv/mqsrb_result_checker.sv
tb/sv/tb_multi_queue_shared_ring_buffer_core.sv
